@@ rtl/qpd_pkg.sv @@
// Package for the quoted-printable decoder: payload structs, queue entry
// type and sizing constants. No dependencies.
`default_nettype none

package qpd_pkg;

    // Width of the count field on the end marker
    localparam int DCNT_W = 32;

    // Default width of the internal saturating byte counter
    localparam int COUNT_BITS_DEF = 32;

    // Queue between front and back (power of two)
    localparam int QD_DEPTH = 4;
    localparam int QD_AW    = 2;

    // One input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // One result beat
    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              stream_end;
        logic [DCNT_W-1:0] decoded_count;
        logic              run_last;
    } t_out;

    // Classified work for one input byte: up to two data bytes, then end marker
    typedef struct packed {
        logic       d0_valid;
        logic [7:0] d0;
        logic       d1_valid;
        logic [7:0] d1;
        logic       end_flag;
    } t_qent;

endpackage : qpd_pkg

`default_nettype wire

@@ rtl/qpd_front.sv @@
// Front part of the quoted-printable decoder: escape state machine that
// turns each input byte into a queue entry. Depends on qpd_pkg.
`default_nettype none

module qpd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire qpd_pkg::t_in i_data,
    output qpd_pkg::t_qent    o_ent,
    output logic              o_ent_valid
);
    import qpd_pkg::*;

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_EQ     = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_BLANK  = 3'd3,
        MODE_CR     = 3'd4
    } t_mode;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Letters A-F and a-f both have low nibble 1..6
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return (c[6]) ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    t_qent      w_ent;
    logic [7:0] w_c;

    assign w_c = i_data.in_byte;

    // Decode the current byte against the escape state
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        w_ent  = '0;
        case (r_mode)
            MODE_EQ, MODE_BLANK: begin
                if (r_mode == MODE_EQ && is_hex(w_c)) begin
                    n_held = w_c;
                    n_mode = MODE_HEX1;
                end else if (w_c == CH_SP || w_c == CH_TAB) begin
                    n_mode = MODE_BLANK;
                end else if (w_c == CH_CR) begin
                    n_mode = MODE_CR;
                end else if (w_c == CH_LF) begin
                    n_mode = MODE_NORMAL;
                end else if (w_c == CH_EQ) begin
                    n_mode = MODE_EQ;
                end else begin
                    n_mode         = MODE_NORMAL;
                    w_ent.d0_valid = 1'b1;
                    w_ent.d0       = w_c;
                end
            end
            MODE_HEX1: begin
                n_held         = '0;
                n_mode         = MODE_NORMAL;
                w_ent.d0_valid = 1'b1;
                if (is_hex(w_c)) begin
                    w_ent.d0 = {hex_val(r_held), hex_val(w_c)};
                end else begin
                    // broken pair: copy the digit, then treat this byte as plain
                    w_ent.d0 = r_held;
                    if (w_c == CH_EQ) begin
                        n_mode = MODE_EQ;
                    end else begin
                        w_ent.d1_valid = 1'b1;
                        w_ent.d1       = w_c;
                    end
                end
            end
            MODE_CR: begin
                if (w_c == CH_LF) begin
                    n_mode = MODE_NORMAL;
                end else if (w_c == CH_EQ) begin
                    n_mode = MODE_EQ;
                end else begin
                    n_mode         = MODE_NORMAL;
                    w_ent.d0_valid = 1'b1;
                    w_ent.d0       = w_c;
                end
            end
            default: begin
                if (w_c == CH_EQ) begin
                    n_mode = MODE_EQ;
                end else begin
                    n_mode         = MODE_NORMAL;
                    w_ent.d0_valid = 1'b1;
                    w_ent.d0       = w_c;
                end
            end
        endcase

        // Close the stream: flush a lone hex digit, add the end marker
        if (i_data.in_last) begin
            if (n_mode == MODE_HEX1) begin
                w_ent.d0_valid = 1'b1;
                w_ent.d0       = n_held;
            end
            w_ent.end_flag = 1'b1;
            n_mode         = MODE_NORMAL;
            n_held         = '0;
        end
    end

    assign o_ent       = w_ent;
    assign o_ent_valid = w_ent.d0_valid | w_ent.d1_valid | w_ent.end_flag;

    // Hold escape state, advance on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_held <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule : qpd_front

`default_nettype wire

@@ rtl/qpd_fifo.sv @@
// Short queue of classified entries between front and back of the decoder.
// Register array with read data taken straight from the head. Depends on qpd_pkg.
`default_nettype none

module qpd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire qpd_pkg::t_qent i_wdata,
    output logic                o_full,
    input  wire logic           i_rd,
    output qpd_pkg::t_qent      o_rdata,
    output logic                o_empty
);
    import qpd_pkg::*;

    t_qent            r_mem [QD_DEPTH];
    logic [QD_AW-1:0] r_wp, r_rp;
    logic [QD_AW:0]   r_count;
    logic             w_wr_ok, w_rd_ok;

    assign o_full  = (r_count == (QD_AW+1)'(QD_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr_ok = i_wr && !o_full;
    assign w_rd_ok = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr_ok && !w_rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd_ok && !w_wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QD_AW+1)'(QD_DEPTH))
        else $error("queue fill count beyond depth");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_ok && !w_rd_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue write without read did not grow fill count");

endmodule : qpd_fifo

`default_nettype wire

@@ rtl/qpd_back.sv @@
// Back part of the quoted-printable decoder: unpacks queue entries into
// result beats and keeps the saturating byte count. Depends on qpd_pkg.
`default_nettype none

module qpd_back #(
    parameter int COUNT_BITS = qpd_pkg::COUNT_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire qpd_pkg::t_qent i_ent,
    input  wire logic           i_ent_empty,
    output logic                o_ent_rd,
    output qpd_pkg::t_out       o_data,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import qpd_pkg::*;

    logic                  r_cur_valid, n_cur_valid;
    t_qent                 r_ent, n_ent;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [DCNT_W-1:0]     w_count_out;
    logic                  w_pop_ok, w_only_one, w_done, w_is_end;

    assign w_pop_ok   = i_pop && r_cur_valid;
    assign w_only_one = $countones({r_ent.d0_valid, r_ent.d1_valid, r_ent.end_flag}) == 1;
    assign w_is_end   = !r_ent.d0_valid && !r_ent.d1_valid;
    assign w_done     = !r_cur_valid || (w_pop_ok && w_only_one);
    assign o_ent_rd   = w_done && !i_ent_empty;
    assign o_empty    = !r_cur_valid;

    // Clamp the counter into the count field
    generate
        if (COUNT_BITS > DCNT_W) begin : g_clamp
            assign w_count_out = (|r_total[COUNT_BITS-1:DCNT_W]) ? '1 :
                                 r_total[DCNT_W-1:0];
        end else begin : g_widen
            assign w_count_out = DCNT_W'(r_total);
        end
    endgenerate

    // Present the oldest pending result of the current entry
    always_comb begin
        o_data          = '0;
        o_data.run_last = w_only_one;
        if (r_ent.d0_valid) begin
            o_data.out_byte   = r_ent.d0;
            o_data.byte_valid = 1'b1;
        end else if (r_ent.d1_valid) begin
            o_data.out_byte   = r_ent.d1;
            o_data.byte_valid = 1'b1;
        end else begin
            o_data.stream_end    = 1'b1;
            o_data.decoded_count = w_count_out;
        end
    end

    // Drop the delivered result, load the next entry when this one is done
    always_comb begin
        n_cur_valid = r_cur_valid;
        n_ent       = r_ent;
        n_total     = r_total;
        if (w_pop_ok) begin
            if (r_ent.d0_valid) begin
                n_ent.d0_valid = 1'b0;
            end else if (r_ent.d1_valid) begin
                n_ent.d1_valid = 1'b0;
            end else begin
                n_ent.end_flag = 1'b0;
            end
            if (w_is_end) begin
                n_total = '0;
            end else if (r_total != {COUNT_BITS{1'b1}}) begin
                n_total = r_total + COUNT_BITS'(1);
            end
        end
        if (o_ent_rd) begin
            n_cur_valid = 1'b1;
            n_ent       = i_ent;
        end else if (w_done) begin
            n_cur_valid = 1'b0;
        end
    end

    // Hold control state; entry payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_ok && w_is_end) |=> (r_total == '0))
        else $error("byte count not cleared after end marker");

    a_live_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_ent.d0_valid || r_ent.d1_valid || r_ent.end_flag))
        else $error("current entry held with nothing left to deliver");

endmodule : qpd_back

`default_nettype wire

@@ rtl/quoted_printable_decoder.sv @@
// Top level of the quoted-printable decoder: front, queue and back.
// Depends on qpd_pkg, qpd_front, qpd_fifo and qpd_back.
//
//  Channel   Handshake          Payload            Direction
//  input     push / full        i_data (t_in)      in
//  result    empty / pop        o_data (t_out)     out
//
// One input beat is taken every cycle while full is low; the escape state
// machine in the front decides each byte in the cycle it is accepted.
// First result of a beat is registered twice when the back is idle: queue write
// at acceptance, then the back's entry load from the queue head.
// The back delivers one result per cycle while pop is high: beats with at most
// one result keep one beat per cycle, beats with two or three results hold the back
// for each result in turn, and the four-entry queue absorbs the difference.
// Synchronous active-low reset clears escape state, queue and byte count.
`default_nettype none

module quoted_printable_decoder #(
    parameter int COUNT_BITS = qpd_pkg::COUNT_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire qpd_pkg::t_in i_data,
    output logic              empty,
    input  wire logic         pop,
    output qpd_pkg::t_out     o_data
);
    import qpd_pkg::*;

    t_qent w_front_ent;
    logic  w_front_valid;
    logic  w_accept;
    t_qent w_q_ent;
    logic  w_q_empty;
    logic  w_q_rd;

    assign w_accept = push && !full;

    qpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data      (i_data),
        .o_ent       (w_front_ent),
        .o_ent_valid (w_front_valid)
    );

    qpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept && w_front_valid),
        .i_wdata (w_front_ent),
        .o_full  (full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_ent),
        .o_empty (w_q_empty)
    );

    qpd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent       (w_q_ent),
        .i_ent_empty (w_q_empty),
        .o_ent_rd    (w_q_rd),
        .o_data      (o_data),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule : quoted_printable_decoder

`default_nettype wire

@@ tb/tb_quoted_printable_decoder.sv @@
// Self-checking testbench for quoted_printable_decoder: a directed table, then random
// encoded streams, with random idling on both queue sides and a scoreboard of results.
// Depends on qpd_pkg and the quoted_printable_decoder RTL.
`timescale 1ns / 100ps

module tb_quoted_printable_decoder;

    import qpd_pkg::*;

    // Escape states of the decoder
    typedef enum logic [2:0] {
        QP_COPY  = 3'd0,
        QP_EQ    = 3'd1,
        QP_HEX1  = 3'd2,
        QP_BLANK = 3'd3,
        QP_CR    = 3'd4
    } qp_mode_e;

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam t_out       NO_RES = '0;
    localparam int         RANDOM_BEATS = 380;
    localparam int         MAX_PRINTS   = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_data  = '0;
    logic full;
    logic empty;
    t_out o_data;

    quoted_printable_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    // Decoder model state
    qp_mode_e    dec_mode;
    logic [7:0]  dec_held;
    logic [31:0] dec_total;

    // Results of the beat being decoded, and all results still owed by the block
    t_out decoded_beats[$];
    t_out pending_results[$];

    // Directed table
    t_in  dir_beat[$];
    bit   dir_typed[$];
    int   dir_n[$];
    t_out dir_e0[$];
    t_out dir_e1[$];
    t_out dir_e2[$];

    int errors      = 0;
    int n_sent      = 0;
    int n_random    = 0;
    int n_checked   = 0;
    int n_markers   = 0;
    int push_calm   = 0;
    int pop_calm    = 0;
    int pop_hold    = 0;

    // Stream generator scratch
    logic [7:0] frag[$];
    int         n_tok;
    int         kind;
    int         k;
    int         j;
    t_in        beat;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout: %0d results still expected", pending_results.size());
        $display("FAIL quoted_printable_decoder");
        $finish;
    end

    function automatic t_out dat(input logic [7:0] b, input logic run);
        t_out r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.run_last   = run;
        return r;
    endfunction

    function automatic t_out eom(input logic [31:0] cnt);
        t_out r;
        r = '0;
        r.stream_end    = 1'b1;
        r.decoded_count = cnt;
        r.run_last      = 1'b1;
        return r;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    function automatic void dec_clear();
        dec_mode  = QP_COPY;
        dec_held  = 8'h00;
        dec_total = 32'd0;
    endfunction

    // Emit one data byte and bump the saturating count
    function automatic void put_byte(input logic [7:0] b);
        decoded_beats.push_back(dat(b, 1'b0));
        if (dec_total != '1) dec_total = dec_total + 32'd1;
    endfunction

    function automatic void copy_byte(input logic [7:0] c);
        if (c == CH_EQ) begin
            dec_mode = QP_EQ;
        end else begin
            dec_mode = QP_COPY;
            put_byte(c);
        end
    endfunction

    // Byte after '=' that is not a hex digit, or any byte after its blanks
    function automatic void after_escape(input logic [7:0] c);
        if (c == CH_SP || c == CH_TAB) dec_mode = QP_BLANK;
        else if (c == CH_CR)           dec_mode = QP_CR;
        else if (c == CH_LF)           dec_mode = QP_COPY;
        else                           copy_byte(c);
    endfunction

    // Decode one input beat into decoded_beats
    function automatic void qp_decode(input t_in b);
        logic [7:0] c;
        c = b.in_byte;
        case (dec_mode)
            QP_EQ: begin
                if (hex_val(c) >= 0) begin
                    dec_held = c;
                    dec_mode = QP_HEX1;
                end else begin
                    after_escape(c);
                end
            end
            QP_HEX1: begin
                dec_mode = QP_COPY;
                if (hex_val(c) >= 0) begin
                    put_byte(8'((hex_val(dec_held) << 4) | hex_val(c)));
                end else begin
                    put_byte(dec_held);
                    copy_byte(c);
                end
                dec_held = 8'h00;
            end
            QP_BLANK: after_escape(c);
            QP_CR: begin
                if (c == CH_LF) dec_mode = QP_COPY;
                else            copy_byte(c);
            end
            default: copy_byte(c);
        endcase
        if (b.in_last) begin
            if (dec_mode == QP_HEX1) put_byte(dec_held);
            decoded_beats.push_back(eom(dec_total));
            dec_clear();
        end
        if (decoded_beats.size() > 0) decoded_beats[decoded_beats.size()-1].run_last = 1'b1;
    endfunction

    // Per-beat wait, with occasional stretches of no idling
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(8, 30);
        return $urandom_range(0, 14);
    endfunction

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        errors = errors + 1;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            report("unexpected result", got, 0);
            return;
        end
        want = pending_results.pop_front();
        n_checked = n_checked + 1;
        if (got.out_byte !== want.out_byte)
            report("out_byte", got.out_byte, want.out_byte);
        if (got.byte_valid !== want.byte_valid)
            report("byte_valid", got.byte_valid, want.byte_valid);
        if (got.stream_end !== want.stream_end)
            report("stream_end", got.stream_end, want.stream_end);
        if (got.decoded_count !== want.decoded_count)
            report("decoded_count", got.decoded_count, want.decoded_count);
        if (got.run_last !== want.run_last)
            report("run_last", got.run_last, want.run_last);
    endtask

    // Result side: check each popped beat, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop_hold = 0;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (o_data.stream_end === 1'b1) n_markers = n_markers + 1;
                check_result(o_data);
                pop_hold = draw_wait(pop_calm);
            end else if (!pop && pop_hold > 0) begin
                pop_hold = pop_hold - 1;
            end
            pop <= (pop_hold == 0);
        end
    end

    // Offer one beat after a random gap; record what it must produce once accepted
    task automatic send_beat(input t_in b, input bit typed, input int n,
                             input t_out e0, input t_out e1, input t_out e2);
        int gap;
        gap = draw_wait(push_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        qp_decode(b);
        if (typed) begin
            if (n > 0) pending_results.push_back(e0);
            if (n > 1) pending_results.push_back(e1);
            if (n > 2) pending_results.push_back(e2);
        end else begin
            foreach (decoded_beats[i]) pending_results.push_back(decoded_beats[i]);
        end
        decoded_beats.delete();
        n_sent = n_sent + 1;
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                           input int n, input t_out e0, input t_out e1, input t_out e2);
        t_in r;
        r.in_byte = b;
        r.in_last = last;
        dir_beat.push_back(r);
        dir_typed.push_back(typed);
        dir_n.push_back(n);
        dir_e0.push_back(e0);
        dir_e1.push_back(e1);
        dir_e2.push_back(e2);
    endtask

    function automatic logic [7:0] hex_char(input int d, input bit lower);
        if (d < 10) return 8'(8'h30 + d);
        return 8'((lower ? 8'h61 : 8'h41) + d - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SP : CH_TAB;
    endfunction

    function automatic logic [7:0] any_hex();
        return hex_char($urandom_range(0, 15), $urandom_range(0, 1));
    endfunction

    initial begin
        dec_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, escapes, soft breaks, cut escapes, end markers
        add_row(8'h00, 1'b0, 1, 1, dat(8'h00, 1'b1), NO_RES, NO_RES);
        add_row(8'hFF, 1'b0, 1, 1, dat(8'hFF, 1'b1), NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h41, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h66, 1'b0, 1, 1, dat(8'hAF, 1'b1), NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_SP, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_TAB, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_CR, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_LF, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h47, 1'b0, 1, 1, dat(8'h47, 1'b1), NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h33, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h7A, 1'b0, 1, 2, dat(8'h33, 1'b0), dat(8'h7A, 1'b1), NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_CR, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h51, 1'b0, 1, 1, dat(8'h51, 1'b1), NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h39, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h78, 1'b1, 1, 3, dat(8'h39, 1'b0), dat(8'h78, 1'b0), eom(32'd9));
        add_row(CH_EQ, 1'b1, 1, 1, eom(32'd0), NO_RES, NO_RES);
        add_row(CH_EQ, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(CH_SP, 1'b1, 0, 0, NO_RES, NO_RES, NO_RES);
        add_row(8'h58, 1'b1, 1, 2, dat(8'h58, 1'b0), eom(32'd1), NO_RES);

        @(posedge i_clk);
        foreach (dir_beat[i])
            send_beat(dir_beat[i], dir_typed[i], dir_n[i], dir_e0[i], dir_e1[i], dir_e2[i]);

        // Random streams built from well-formed escapes with noise mixed in
        while (n_random < RANDOM_BEATS) begin
            n_tok = $urandom_range(1, 12);
            for (k = 0; k < n_tok; k++) begin
                frag.delete();
                kind = $urandom_range(0, 99);
                if (kind < 25) begin
                    frag.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end else if (kind < 35) begin
                    frag.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 60) begin
                    frag.push_back(CH_EQ);
                    frag.push_back(any_hex());
                    frag.push_back(any_hex());
                end else if (kind < 75) begin
                    // Soft break; the last choice leaves it with no line end after it
                    frag.push_back(CH_EQ);
                    repeat ($urandom_range(0, 3)) frag.push_back(blank_char());
                    case ($urandom_range(0, 3))
                        0: begin
                            frag.push_back(CH_CR);
                            frag.push_back(CH_LF);
                        end
                        1: frag.push_back(CH_CR);
                        2: frag.push_back(CH_LF);
                        default: ;
                    endcase
                end else if (kind < 82) begin
                    frag.push_back(CH_EQ);
                    frag.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 88) begin
                    frag.push_back(CH_EQ);
                    frag.push_back(any_hex());
                    if ($urandom_range(0, 3) != 0) frag.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 93) begin
                    frag.push_back(CH_EQ);
                    repeat ($urandom_range(1, 3)) frag.push_back(blank_char());
                    frag.push_back(8'($urandom_range(0, 255)));
                end else begin
                    frag.push_back(CH_EQ);
                    repeat ($urandom_range(0, 2)) frag.push_back(blank_char());
                    frag.push_back(CH_CR);
                    frag.push_back(8'($urandom_range(0, 255)));
                end
                for (j = 0; j < frag.size(); j++) begin
                    beat.in_byte = frag[j];
                    beat.in_last = (k == n_tok - 1) && (j == frag.size() - 1);
                    send_beat(beat, 1'b0, 0, NO_RES, NO_RES, NO_RES);
                    n_random = n_random + 1;
                end
            end
        end
        push <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d input beats (%0d random), %0d results checked, %0d streams ended",
                 n_sent, n_random, n_checked, n_markers);
        $display("escapes, soft breaks, broken and cut escapes; %0d mismatches", errors);
        if (errors == 0) begin
            $display("PASS quoted_printable_decoder");
        end else begin
            $display("FAIL quoted_printable_decoder");
        end
        $finish;
    end

endmodule

@@ quoted_printable_decoder.f @@
rtl/qpd_pkg.sv
rtl/qpd_front.sv
rtl/qpd_fifo.sv
rtl/qpd_back.sv
rtl/quoted_printable_decoder.sv
tb/tb_quoted_printable_decoder.sv
